// ===== rtl/tmc_pkg.sv =====
// Shared types, codes and constants for the touch median calibration block.
// Depends on nothing; every other file takes names from here by scope.
`timescale 1ns / 1ps

package tmc_pkg;

  localparam int SAMPLE_COUNT_DEF = 5;
  localparam int SAMPLE_BITS      = 12;
  localparam int DATA_W           = 12;
  localparam int SIZE_W           = 13;

  // Stored samples keep the conversion bits that the sample width allows.
  localparam logic [DATA_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((1 << SAMPLE_BITS) - 1);

  // Restoring division of a 24-bit product by a 12-bit span, one bit a cycle.
  localparam int          DIV_STEPS = DATA_W;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  // Input operation codes.
  localparam logic OP_PRESSURE = 1'b0;
  localparam logic OP_PAIR     = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_EDGE  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_PRESSURE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_EDGE_LIMIT         = 3'd1;
  localparam logic [2:0] REG_RAW_X_LOW          = 3'd2;
  localparam logic [2:0] REG_RAW_X_HIGH         = 3'd3;
  localparam logic [2:0] REG_RAW_Y_LOW          = 3'd4;
  localparam logic [2:0] REG_RAW_Y_HIGH         = 3'd5;
  localparam logic [2:0] REG_PANEL_WIDTH        = 3'd6;
  localparam logic [2:0] REG_PANEL_HEIGHT       = 3'd7;

  // Register reset values.
  localparam logic [DATA_W-1:0] RST_PRESSURE_THRESHOLD = 12'd100;
  localparam logic [DATA_W-1:0] RST_EDGE_LIMIT         = 12'd50;
  localparam logic [DATA_W-1:0] RST_RAW_LOW            = 12'd200;
  localparam logic [DATA_W-1:0] RST_RAW_HIGH           = 12'd3900;
  localparam logic [SIZE_W-1:0] RST_PANEL_WIDTH        = 13'd240;
  localparam logic [SIZE_W-1:0] RST_PANEL_HEIGHT       = 13'd320;

  typedef struct packed {
    logic start;
    logic wr_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [SIZE_W-1:0] size;
  } lane_cal_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] median;
    logic [DATA_W-1:0] mapped;
    logic [DATA_W-1:0] last;
  } lane_stat_t;

endpackage

// ===== rtl/touch_median_calibrate_core.sv =====
// Top level of the touch median calibration block: register file, capture
// control, two axis lanes and the merging stage. Depends on tmc_pkg, tmc_lane.
`timescale 1ns / 1ps

// Channel | Handshake         | Beat contents
// --------+-------------------+-----------------------------------------------
// input   | in_valid/in_stall | op, pressure_value, sample_x, sample_y
// output  | out_valid/out_stall| status, pixel_x, pixel_y, median_x, median_y
// config  | APB psel/penable  | paddr (register at 4*index), pwdata, prdata
//
// Pressure beats and every pair but the last of a capture need no lane work.
// The last pair starts both lanes: median search, clamp, multiplier and the
// bit-serial divider (a median at or beyond the raw limits skips the last
// two), then the merging stage loads the output. The input stalls for that
// whole time; beyond it, a low-pressure beat is held back only while an
// earlier result is stalled. Reset is synchronous and active high; it
// restores the register defaults and disarms any capture.

module touch_median_calibrate_core #(
  parameter int SAMPLE_COUNT = tmc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [11:0] pressure_value,
  input  logic [11:0] sample_x,
  input  logic [11:0] sample_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] pixel_x,
  output logic [11:0] pixel_y,
  output logic [11:0] median_x,
  output logic [11:0] median_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(SAMPLE_COUNT);
  localparam int CW = $clog2(SAMPLE_COUNT + 1);

  // Configuration registers.
  logic [11:0] pressure_threshold;
  logic [11:0] edge_limit;
  logic [11:0] raw_x_low;
  logic [11:0] raw_x_high;
  logic [11:0] raw_y_low;
  logic [11:0] raw_y_high;
  logic [12:0] panel_width;
  logic [12:0] panel_height;

  // Capture control.
  logic          capture_armed;
  logic [CW-1:0] sample_count;
  logic          busy;

  logic                 in_accept;
  logic                 low_press;
  logic                 load_low;
  logic                 out_free;
  logic                 finish;
  logic                 last_pair;
  logic [2:0]           reg_idx;
  tmc_pkg::lane_ctrl_t  lane_ctrl;
  tmc_pkg::lane_cal_t   cal_x;
  tmc_pkg::lane_cal_t   cal_y;
  tmc_pkg::lane_stat_t  stat_x;
  tmc_pkg::lane_stat_t  stat_y;
  logic [11:0]          sx_masked;
  logic [11:0]          sy_masked;

  // ---------------------------------------------------------------------
  // APB register file. Writes complete in the access phase; pready is tied
  // high so no wait states are ever inserted.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_threshold <= tmc_pkg::RST_PRESSURE_THRESHOLD;
      edge_limit         <= tmc_pkg::RST_EDGE_LIMIT;
      raw_x_low          <= tmc_pkg::RST_RAW_LOW;
      raw_x_high         <= tmc_pkg::RST_RAW_HIGH;
      raw_y_low          <= tmc_pkg::RST_RAW_LOW;
      raw_y_high         <= tmc_pkg::RST_RAW_HIGH;
      panel_width        <= tmc_pkg::RST_PANEL_WIDTH;
      panel_height       <= tmc_pkg::RST_PANEL_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        tmc_pkg::REG_PRESSURE_THRESHOLD: pressure_threshold <= pwdata[11:0];
        tmc_pkg::REG_EDGE_LIMIT:         edge_limit         <= pwdata[11:0];
        tmc_pkg::REG_RAW_X_LOW:          raw_x_low          <= pwdata[11:0];
        tmc_pkg::REG_RAW_X_HIGH:         raw_x_high         <= pwdata[11:0];
        tmc_pkg::REG_RAW_Y_LOW:          raw_y_low          <= pwdata[11:0];
        tmc_pkg::REG_RAW_Y_HIGH:         raw_y_high         <= pwdata[11:0];
        tmc_pkg::REG_PANEL_WIDTH:        panel_width        <= pwdata[12:0];
        tmc_pkg::REG_PANEL_HEIGHT:       panel_height       <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmc_pkg::REG_PRESSURE_THRESHOLD: prdata = {20'd0, pressure_threshold};
      tmc_pkg::REG_EDGE_LIMIT:         prdata = {20'd0, edge_limit};
      tmc_pkg::REG_RAW_X_LOW:          prdata = {20'd0, raw_x_low};
      tmc_pkg::REG_RAW_X_HIGH:         prdata = {20'd0, raw_x_high};
      tmc_pkg::REG_RAW_Y_LOW:          prdata = {20'd0, raw_y_low};
      tmc_pkg::REG_RAW_Y_HIGH:         prdata = {20'd0, raw_y_high};
      tmc_pkg::REG_PANEL_WIDTH:        prdata = {19'd0, panel_width};
      tmc_pkg::REG_PANEL_HEIGHT:       prdata = {19'd0, panel_height};
      default:                         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input handshake and capture sequencing. Everything stalls while the
  // lanes are at work. A low-pressure beat produces a result at once, so it
  // waits only when the output register is full and cannot drain.
  // ---------------------------------------------------------------------
  assign low_press = pressure_value < pressure_threshold;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = busy || (!out_free && (op == tmc_pkg::OP_PRESSURE) && low_press);
  assign in_accept = in_valid && !in_stall;
  assign load_low  = in_accept && (op == tmc_pkg::OP_PRESSURE) && low_press;
  assign last_pair = sample_count == CW'(SAMPLE_COUNT - 1);

  assign lane_ctrl.wr_en = in_accept && (op == tmc_pkg::OP_PAIR) && capture_armed;
  assign lane_ctrl.start = lane_ctrl.wr_en && last_pair;

  assign sx_masked = sample_x & tmc_pkg::SAMPLE_MASK;
  assign sy_masked = sample_y & tmc_pkg::SAMPLE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_armed <= 1'b0;
      sample_count  <= '0;
      busy          <= 1'b0;
    end else begin
      if (in_accept && (op == tmc_pkg::OP_PRESSURE)) begin
        // A pressure beat drops any pairs gathered so far; a firm press re-arms.
        sample_count  <= '0;
        capture_armed <= !low_press;
      end else if (lane_ctrl.start) begin
        sample_count  <= '0;
        capture_armed <= 1'b0;
      end else if (lane_ctrl.wr_en) begin
        sample_count <= sample_count + CW'(1);
      end
      if (lane_ctrl.start) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Axis lanes. The x lane maps onto the rows and the y lane onto the
  // columns, since the panel is mounted with its axes swapped.
  // ---------------------------------------------------------------------
  assign cal_x.lo   = raw_x_low;
  assign cal_x.hi   = raw_x_high;
  assign cal_x.size = panel_height;
  assign cal_y.lo   = raw_y_low;
  assign cal_y.hi   = raw_y_high;
  assign cal_y.size = panel_width;

  tmc_lane #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .wr_idx  (sample_count[IW-1:0]),
    .wr_data (sx_masked),
    .cal     (cal_x),
    .stat    (stat_x)
  );

  tmc_lane #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .wr_idx  (sample_count[IW-1:0]),
    .wr_data (sy_masked),
    .cal     (cal_y),
    .stat    (stat_y)
  );

  // ---------------------------------------------------------------------
  // Merging stage and output register. The lanes hold their results until
  // the output register has room, so a stalled output never loses a touch.
  // The column is mirrored: the largest raw y lands on column zero.
  // ---------------------------------------------------------------------
  assign finish = busy && stat_x.done && stat_y.done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_low || finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_low) begin
      status   <= tmc_pkg::ST_LOW;
      pixel_x  <= '0;
      pixel_y  <= '0;
      median_x <= '0;
      median_y <= '0;
    end else if (finish) begin
      median_x <= stat_x.median;
      median_y <= stat_y.median;
      if ((stat_x.median < edge_limit) || (stat_y.median < edge_limit)) begin
        status  <= tmc_pkg::ST_EDGE;
        pixel_x <= '0;
        pixel_y <= '0;
      end else begin
        status  <= tmc_pkg::ST_VALID;
        pixel_x <= stat_y.last - stat_y.mapped;
        pixel_y <= stat_x.mapped;
      end
    end
  end

endmodule

// ===== rtl/tmc_lane.sv =====
// One axis lane: sample store, rank-based median search, clamp and linear map
// with a bit-serial divider. Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_lane #(
  parameter int SAMPLE_COUNT = tmc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tmc_pkg::lane_ctrl_t              ctrl,
  input  logic [$clog2(SAMPLE_COUNT)-1:0]  wr_idx,
  input  logic [tmc_pkg::DATA_W-1:0]       wr_data,
  input  tmc_pkg::lane_cal_t               cal,
  output tmc_pkg::lane_stat_t              stat
);

  localparam int IW  = $clog2(SAMPLE_COUNT);
  localparam int DW  = tmc_pkg::DATA_W;
  localparam int MID = SAMPLE_COUNT / 2;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MED  = 3'd1;
  localparam logic [2:0] L_MAP  = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_DIV  = 3'd4;
  localparam logic [2:0] L_DONE = 3'd5;

  logic [DW-1:0] store [SAMPLE_COUNT];
  logic [2:0]    state;
  logic [IW-1:0] cand;
  logic [3:0]    step;
  logic [DW-1:0] median;
  logic [DW-1:0] diff;
  logic [DW-1:0] span;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] mapped;

  logic [DW-1:0] cand_val;
  logic [IW-1:0] rank;
  logic [DW-1:0] last;
  logic [DW:0]   trial;
  logic          ge;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  // A candidate's stable rank counts smaller entries and equal entries
  // stored ahead of it; exactly one entry has the middle rank.
  always_comb begin
    cand_val = store[cand];
    rank     = '0;
    for (int j = 0; j < SAMPLE_COUNT; j++) begin
      if ((store[j] < cand_val) || ((IW'(j) < cand) && (store[j] == cand_val))) begin
        rank = rank + IW'(1);
      end
    end
  end

  always_comb begin
    if (cal.size == '0) begin
      last = '0;
    end else if (cal.size > tmc_pkg::SIZE_MAX) begin
      last = {DW{1'b1}};
    end else begin
      last = DW'(cal.size - 13'd1);
    end
  end

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else if (ctrl.start) begin
      state <= L_MED;
      cand  <= '0;
    end else begin
      case (state)
        L_MED: begin
          if (rank == IW'(MID)) begin
            median <= cand_val;
          end
          if (cand == IW'(SAMPLE_COUNT - 1)) begin
            state <= L_MAP;
          end else begin
            cand <= cand + IW'(1);
          end
        end
        L_MAP: begin
          if (median <= cal.lo) begin
            mapped <= '0;
            state  <= L_DONE;
          end else if (median >= cal.hi) begin
            mapped <= last;
            state  <= L_DONE;
          end else begin
            diff  <= median - cal.lo;
            span  <= cal.hi - cal.lo;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          {rem, quo} <= (2*DW)'(diff) * (2*DW)'(last);
          step       <= '0;
          state      <= L_DIV;
        end
        L_DIV: begin
          rem <= ge ? DW'(trial - {1'b0, span}) : trial[DW-1:0];
          quo <= {quo[DW-2:0], ge};
          if (step == tmc_pkg::DIV_LAST) begin
            mapped <= {quo[DW-2:0], ge};
            state  <= L_DONE;
          end else begin
            step <= step + 4'd1;
          end
        end
        L_DONE: begin
          state <= L_DONE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign stat.done   = (state == L_DONE);
  assign stat.median = median;
  assign stat.mapped = mapped;
  assign stat.last   = last;

endmodule

// ===== rtl/tmc_checker.sv =====
// Port-level checks on the result channel of the touch median calibration
// block, bound to the top level. Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [11:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [11:0] median_x,
  input logic [11:0] median_y
);

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A rejected touch carries no pixel position.
  a_reject_no_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != tmc_pkg::ST_VALID) |-> (pixel_x == '0) && (pixel_y == '0))
    else $error("rejected touch shows a pixel position");

  // A low-pressure beat has no samples behind it, so its medians are zero.
  a_low_no_median: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tmc_pkg::ST_LOW) |-> (median_x == '0) && (median_y == '0))
    else $error("low-pressure result shows medians");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind touch_median_calibrate_core tmc_checker u_tmc_checker (.*);
